[src/tdo_pkg.sv]
package tdo_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_BITS  = 4;
  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 8;
  localparam int RAD_BITS   = 10;
  localparam int RSQ_BITS   = 2 * RAD_BITS;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int DIST_BITS  = SQ_BITS + 1;
  localparam int ACT_BITS   = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = RAD_BITS;

  // item kinds
  localparam logic [ACT_BITS-1:0] ACT_PIXEL = 2'd0;
  localparam logic [ACT_BITS-1:0] ACT_MOVE  = 2'd1;
  localparam logic [ACT_BITS-1:0] ACT_DOWN  = 2'd2;
  localparam logic [ACT_BITS-1:0] ACT_UP    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TOUCH_RED   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOUCH_GREEN = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOUCH_BLUE  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERT_MODE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MOVE_RADIUS = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DOWN_RADIUS = 3'd5;

  localparam logic [COLOR_BITS-1:0] COLOR_FULL = 8'hFF;

  // reset values, radius squares precomputed
  localparam logic [COLOR_BITS-1:0] RST_TOUCH_RED   = 8'd255;
  localparam logic [COLOR_BITS-1:0] RST_TOUCH_GREEN = 8'd0;
  localparam logic [COLOR_BITS-1:0] RST_TOUCH_BLUE  = 8'd0;
  localparam logic [RSQ_BITS-1:0]   RST_MOVE_RSQ    = RSQ_BITS'(16 * 16);
  localparam logic [RSQ_BITS-1:0]   RST_DOWN_RSQ    = RSQ_BITS'(24 * 24);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [RSQ_BITS-1:0]   rsq_t;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
    color_t alpha;
  } pixel_t;

endpackage

[src/tdo_lane.sv]
module tdo_lane (
  input  logic           clk,
  input  logic           load,
  input  tdo_pkg::coord_t pix_x,
  input  tdo_pkg::coord_t pix_y,
  input  tdo_pkg::coord_t slot_x,
  input  tdo_pkg::coord_t slot_y,
  input  logic           slot_on,
  input  logic           slot_down,
  input  tdo_pkg::rsq_t  move_rsq,
  input  tdo_pkg::rsq_t  down_rsq,
  output logic           hit
);

  tdo_pkg::coord_t dx;
  tdo_pkg::coord_t dy;
  logic [tdo_pkg::SQ_BITS-1:0]   dxsq_nxt;
  logic [tdo_pkg::SQ_BITS-1:0]   dysq_nxt;
  logic [tdo_pkg::SQ_BITS-1:0]   dxsq_r;
  logic [tdo_pkg::SQ_BITS-1:0]   dysq_r;
  logic                          on_r;
  logic                          down_r;
  logic [tdo_pkg::DIST_BITS-1:0] dist_sum;
  tdo_pkg::rsq_t                 rsq;

  assign dx = (pix_x >= slot_x) ? (pix_x - slot_x) : (slot_x - pix_x);
  assign dy = (pix_y >= slot_y) ? (pix_y - slot_y) : (slot_y - pix_y);
  assign dxsq_nxt = tdo_pkg::SQ_BITS'(dx) * tdo_pkg::SQ_BITS'(dx);
  assign dysq_nxt = tdo_pkg::SQ_BITS'(dy) * tdo_pkg::SQ_BITS'(dy);

  always_ff @(posedge clk) begin
    if (load) begin
      dxsq_r <= dxsq_nxt;
      dysq_r <= dysq_nxt;
      on_r   <= slot_on;
      down_r <= slot_down;
    end
  end

  assign dist_sum = tdo_pkg::DIST_BITS'(dxsq_r) + tdo_pkg::DIST_BITS'(dysq_r);
  assign rsq      = down_r ? down_rsq : move_rsq;
  assign hit      = on_r && (dist_sum <= tdo_pkg::DIST_BITS'(rsq));

endmodule

[src/touch_disc_overlay.sv]
// touch_disc_overlay: paints filled touch discs over a pixel stream.
// input channel (in_valid/in_ready) carries either a pixel (in_action pixel)
// or a touch event (move, down, up) for slot in_slot at in_pos_x/in_pos_y.
// events update the slot table and give no result; each pixel gives one
// result on the output channel (out_valid/out_ready) with its color, alpha
// and out_covered.
// cfg_we/cfg_index/cfg_wdata write the color, mode and radius registers;
// write only while the block is idle. radius squares are formed at write.
// throughput: one item per clock while the output is not stalled. a pixel
// passes through the input register, the squares register and the output
// register in turn. every slot has its own distance lane, so the slot
// count does not change the rate.
// reset (rst_n low, synchronous) empties all slots and the pipeline and
// loads default color red, color mode, radii 16 and 24.
// when the receiver stalls the pipeline holds; in_ready stays high until
// all stages are full, and events still drain from the input register.
module touch_disc_overlay (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tdo_pkg::ACT_BITS-1:0]       in_action,
  input  logic [tdo_pkg::SLOT_BITS-1:0]      in_slot,
  input  tdo_pkg::coord_t                    in_pos_x,
  input  tdo_pkg::coord_t                    in_pos_y,
  input  tdo_pkg::color_t                    in_red,
  input  tdo_pkg::color_t                    in_green,
  input  tdo_pkg::color_t                    in_blue,
  input  tdo_pkg::color_t                    in_alpha,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tdo_pkg::color_t                    out_red,
  output tdo_pkg::color_t                    out_green,
  output tdo_pkg::color_t                    out_blue,
  output tdo_pkg::color_t                    out_alpha,
  output logic                               out_covered,
  input  logic                               cfg_we,
  input  logic [tdo_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tdo_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  // configuration
  tdo_pkg::color_t touch_red_r;
  tdo_pkg::color_t touch_green_r;
  tdo_pkg::color_t touch_blue_r;
  logic            invert_mode_r;
  tdo_pkg::rsq_t   move_rsq_r;
  tdo_pkg::rsq_t   down_rsq_r;
  tdo_pkg::rsq_t   cfg_rsq;

  // slot table
  logic [tdo_pkg::SLOTS-1:0] slot_valid_r;
  logic [tdo_pkg::SLOTS-1:0] slot_down_r;
  tdo_pkg::coord_t           slot_x_r [tdo_pkg::SLOTS];
  tdo_pkg::coord_t           slot_y_r [tdo_pkg::SLOTS];

  // stage 1: input register
  logic                              s1_valid_r;
  logic [tdo_pkg::ACT_BITS-1:0]      s1_action_r;
  logic [tdo_pkg::SLOT_BITS-1:0]     s1_slot_r;
  tdo_pkg::coord_t                   s1_x_r;
  tdo_pkg::coord_t                   s1_y_r;
  tdo_pkg::pixel_t                   s1_pix_r;

  // stage 2: squares in the lanes
  logic                      s2_valid_r;
  tdo_pkg::pixel_t           s2_pix_r;
  logic [tdo_pkg::SLOTS-1:0] hits;

  // stage 3: output register
  logic                      out_valid_r;
  tdo_pkg::pixel_t           out_pix_r;
  tdo_pkg::pixel_t           out_pix_nxt;
  logic                      out_covered_r;

  logic in_xfer;
  logic s1_is_event;
  logic s1_leave;
  logic s2_load;
  logic s2_free;
  logic out_free;
  logic out_load;
  logic slot_in_range;
  logic any_hit;
  logic odd_hits;

  assign cfg_rsq = tdo_pkg::RSQ_BITS'(cfg_wdata) * tdo_pkg::RSQ_BITS'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_red_r   <= tdo_pkg::RST_TOUCH_RED;
      touch_green_r <= tdo_pkg::RST_TOUCH_GREEN;
      touch_blue_r  <= tdo_pkg::RST_TOUCH_BLUE;
      invert_mode_r <= 1'b0;
      move_rsq_r    <= tdo_pkg::RST_MOVE_RSQ;
      down_rsq_r    <= tdo_pkg::RST_DOWN_RSQ;
    end else if (cfg_we) begin
      case (cfg_index)
        tdo_pkg::REG_TOUCH_RED:   touch_red_r   <= cfg_wdata[tdo_pkg::COLOR_BITS-1:0];
        tdo_pkg::REG_TOUCH_GREEN: touch_green_r <= cfg_wdata[tdo_pkg::COLOR_BITS-1:0];
        tdo_pkg::REG_TOUCH_BLUE:  touch_blue_r  <= cfg_wdata[tdo_pkg::COLOR_BITS-1:0];
        tdo_pkg::REG_INVERT_MODE: invert_mode_r <= cfg_wdata[0];
        tdo_pkg::REG_MOVE_RADIUS: move_rsq_r    <= cfg_rsq;
        tdo_pkg::REG_DOWN_RADIUS: down_rsq_r    <= cfg_rsq;
        default: ;
      endcase
    end
  end

  // pipeline control
  assign out_free    = !out_valid_r || out_ready;
  assign out_load    = s2_valid_r && out_free;
  assign s2_free     = !s2_valid_r || out_free;
  assign s1_is_event = (s1_action_r != tdo_pkg::ACT_PIXEL);
  assign s1_leave    = s1_valid_r && (s1_is_event || s2_free);
  assign s2_load     = s1_valid_r && !s1_is_event && s2_free;
  assign in_ready    = !s1_valid_r || s1_leave;
  assign in_xfer     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_leave) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_r <= 1'b1;
      end else if (out_free) begin
        s2_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_action_r    <= in_action;
      s1_slot_r      <= in_slot;
      s1_x_r         <= in_pos_x;
      s1_y_r         <= in_pos_y;
      s1_pix_r.red   <= in_red;
      s1_pix_r.green <= in_green;
      s1_pix_r.blue  <= in_blue;
      s1_pix_r.alpha <= in_alpha;
    end
    if (s2_load) begin
      s2_pix_r <= s1_pix_r;
    end
    if (out_load) begin
      out_pix_r     <= out_pix_nxt;
      out_covered_r <= any_hit;
    end
  end

  // events take effect as they leave stage 1, so earlier pixels saw the old table
  assign slot_in_range = (32'(s1_slot_r) < tdo_pkg::SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      slot_down_r  <= '0;
    end else if (s1_leave && s1_is_event && slot_in_range) begin
      if (s1_action_r == tdo_pkg::ACT_UP) begin
        slot_valid_r[s1_slot_r] <= 1'b0;
      end else begin
        slot_valid_r[s1_slot_r] <= 1'b1;
        slot_down_r[s1_slot_r]  <= (s1_action_r == tdo_pkg::ACT_DOWN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_leave && s1_is_event && slot_in_range && (s1_action_r != tdo_pkg::ACT_UP)) begin
      slot_x_r[s1_slot_r] <= s1_x_r;
      slot_y_r[s1_slot_r] <= s1_y_r;
    end
  end

  for (genvar i = 0; i < tdo_pkg::SLOTS; i++) begin : g_lane
    tdo_lane u_lane (
      .clk       (clk),
      .load      (s2_load),
      .pix_x     (s1_x_r),
      .pix_y     (s1_y_r),
      .slot_x    (slot_x_r[i]),
      .slot_y    (slot_y_r[i]),
      .slot_on   (slot_valid_r[i]),
      .slot_down (slot_down_r[i]),
      .move_rsq  (move_rsq_r),
      .down_rsq  (down_rsq_r),
      .hit       (hits[i])
    );
  end

  assign any_hit  = |hits;
  assign odd_hits = ^hits;

  always_comb begin
    out_pix_nxt = s2_pix_r;
    if (any_hit) begin
      if (invert_mode_r) begin
        if (odd_hits) begin
          out_pix_nxt.red   = s2_pix_r.red ^ tdo_pkg::COLOR_FULL;
          out_pix_nxt.green = s2_pix_r.green ^ tdo_pkg::COLOR_FULL;
          out_pix_nxt.blue  = s2_pix_r.blue ^ tdo_pkg::COLOR_FULL;
        end
      end else begin
        out_pix_nxt.red   = touch_red_r;
        out_pix_nxt.green = touch_green_r;
        out_pix_nxt.blue  = touch_blue_r;
        out_pix_nxt.alpha = tdo_pkg::COLOR_FULL;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_red     = out_pix_r.red;
  assign out_green   = out_pix_r.green;
  assign out_blue    = out_pix_r.blue;
  assign out_alpha   = out_pix_r.alpha;
  assign out_covered = out_covered_r;

  a_up_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_leave && s1_action_r == tdo_pkg::ACT_UP)
    |=> !slot_valid_r[$past(s1_slot_r)])
    else $error("up event did not clear its slot");

  a_touch_stores_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_leave && (s1_action_r == tdo_pkg::ACT_MOVE || s1_action_r == tdo_pkg::ACT_DOWN))
    |=> slot_valid_r[$past(s1_slot_r)] && slot_x_r[$past(s1_slot_r)] == $past(s1_x_r)
        && slot_y_r[$past(s1_slot_r)] == $past(s1_y_r))
    else $error("touch event did not store its slot");

  a_result_from_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r))
    else $error("result appeared without a pixel in stage 2");

  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_free) |=> s2_valid_r && $stable(s2_pix_r))
    else $error("stalled pixel lost in stage 2");

  a_paint_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_covered_r && !invert_mode_r)
    |-> out_pix_r.alpha == tdo_pkg::COLOR_FULL)
    else $error("painted pixel without full alpha");

endmodule

[verif/touch_disc_overlay_test.sv]
`timescale 1ns / 100ps

module touch_disc_overlay_test;

  localparam int DIR_ROWS     = 25;
  localparam int INVERT_FROM  = 17;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 100;
  localparam int HOLD_CYCLES  = 60;
  localparam int SETTLE       = 8;
  localparam int MOVE_RAD_RST = 16;
  localparam int DOWN_RAD_RST = 24;
  localparam int COORD_MAX    = (1 << tdo_pkg::COORD_BITS) - 1;

  typedef struct packed {
    tdo_pkg::pixel_t pix;
    logic            covered;
  } shade_t;

  typedef struct packed {
    logic [tdo_pkg::ACT_BITS-1:0]  action;
    logic [tdo_pkg::SLOT_BITS-1:0] slot;
    tdo_pkg::coord_t               pos_x;
    tdo_pkg::coord_t               pos_y;
    tdo_pkg::pixel_t               pix;
    logic                          pin;
    shade_t                        pin_exp;
  } item_t;

  localparam shade_t NO_PIN = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  item_t offer = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tdo_pkg::color_t out_red, out_green, out_blue, out_alpha;
  logic out_covered;
  logic cfg_we = 1'b0;
  logic [tdo_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [tdo_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // stimulus controls
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int unsigned fails = 0;

  // predictor copy of the slot table and registers
  bit disc_on [tdo_pkg::SLOTS];
  bit disc_down [tdo_pkg::SLOTS];
  tdo_pkg::coord_t disc_x [tdo_pkg::SLOTS];
  tdo_pkg::coord_t disc_y [tdo_pkg::SLOTS];
  tdo_pkg::color_t paint_red, paint_green, paint_blue;
  bit paint_invert;
  int unsigned move_rad, down_rad;
  shade_t shade_q [$];

  // last touch point per slot (near_x may also take the x of another slot's touch), steers pixels toward discs
  int near_x [tdo_pkg::SLOTS];
  int near_y [tdo_pkg::SLOTS];

  // default color red, radii 16 and 24 until the invert rows
  item_t directed_items [DIR_ROWS] = '{
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd0,    12'd0,    32'h0c22384e, 1'b1, '{32'h0c22384e, 1'b0}},
    '{tdo_pkg::ACT_PIXEL, 4'd9,  12'd4095, 12'd4095, 32'hffffffff, 1'b1, '{32'hffffffff, 1'b0}},
    '{tdo_pkg::ACT_DOWN,  4'd0,  12'd100,  12'd100,  32'h00000000, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd100,  12'd100,  32'h01020304, 1'b1, '{32'hff0000ff, 1'b1}},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd124,  12'd100,  32'h10203040, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd125,  12'd100,  32'h10203040, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_MOVE,  4'd15, 12'd4095, 12'd4095, 32'h00000000, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd4079, 12'd4095, 32'haa55aa55, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd4084, 12'd4083, 32'h55aa55aa, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_MOVE,  4'd0,  12'd0,    12'd0,    32'h00000000, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd16,   12'd0,    32'h80808080, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd100,  12'd100,  32'h80808080, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_UP,    4'd3,  12'd0,    12'd0,    32'h00000000, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_UP,    4'd15, 12'd0,    12'd0,    32'h00000000, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd4095, 12'd4095, 32'h7f7f7f7f, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_DOWN,  4'd7,  12'd0,    12'd4095, 32'h00000000, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd0,    12'd4095, 32'h00000000, 1'b0, NO_PIN},
    // invert mode, move radius 0, down radius 1023
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd0,    12'd0,    32'h12345678, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd1,    12'd0,    32'h12345678, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_DOWN,  4'd1,  12'd0,    12'd0,    32'h00000000, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd0,    12'd0,    32'h12345678, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd0,    12'd10,   32'h9abcdef0, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd1023, 12'd0,    32'hc3c3c3c3, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_PIXEL, 4'd0,  12'd1023, 12'd1,    32'h3c3c3c3c, 1'b0, NO_PIN},
    '{tdo_pkg::ACT_UP,    4'd1,  12'd0,    12'd0,    32'h00000000, 1'b0, NO_PIN}
  };

  touch_disc_overlay i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (offer.action),
    .in_slot     (offer.slot),
    .in_pos_x    (offer.pos_x),
    .in_pos_y    (offer.pos_y),
    .in_red      (offer.pix.red),
    .in_green    (offer.pix.green),
    .in_blue     (offer.pix.blue),
    .in_alpha    (offer.pix.alpha),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .out_covered (out_covered),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned gap(tdo_pkg::coord_t a, tdo_pkg::coord_t b);
    return (a > b) ? 32'(a - b) : 32'(b - a);
  endfunction

  function automatic shade_t shade_pixel(item_t it);
    int unsigned hits, dx, dy, rad;
    shade_t res;
    hits = 0;
    for (int i = 0; i < tdo_pkg::SLOTS; i++) begin
      if (disc_on[i]) begin
        rad = disc_down[i] ? down_rad : move_rad;
        dx = gap(it.pos_x, disc_x[i]);
        dy = gap(it.pos_y, disc_y[i]);
        if (dx * dx + dy * dy <= rad * rad) hits++;
      end
    end
    res.pix = it.pix;
    res.covered = (hits != 0);
    if (hits != 0) begin
      if (paint_invert) begin
        // even overlap cancels out
        if (hits[0]) begin
          res.pix.red   = it.pix.red ^ tdo_pkg::COLOR_FULL;
          res.pix.green = it.pix.green ^ tdo_pkg::COLOR_FULL;
          res.pix.blue  = it.pix.blue ^ tdo_pkg::COLOR_FULL;
        end
      end else begin
        res.pix = '{paint_red, paint_green, paint_blue, tdo_pkg::COLOR_FULL};
      end
    end
    return res;
  endfunction

  function automatic int unsigned field_bad(string name, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, actual %0d", name, want, got);
    return 1;
  endfunction

  // predictor and result check
  always @(posedge clk) begin
    shade_t want;
    if (!rst_n) begin
      foreach (disc_on[i]) begin
        disc_on[i] = 1'b0;
        disc_down[i] = 1'b0;
      end
      paint_red = tdo_pkg::RST_TOUCH_RED;
      paint_green = tdo_pkg::RST_TOUCH_GREEN;
      paint_blue = tdo_pkg::RST_TOUCH_BLUE;
      paint_invert = 1'b0;
      move_rad = MOVE_RAD_RST;
      down_rad = DOWN_RAD_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tdo_pkg::REG_TOUCH_RED:   paint_red = cfg_wdata[tdo_pkg::COLOR_BITS-1:0];
          tdo_pkg::REG_TOUCH_GREEN: paint_green = cfg_wdata[tdo_pkg::COLOR_BITS-1:0];
          tdo_pkg::REG_TOUCH_BLUE:  paint_blue = cfg_wdata[tdo_pkg::COLOR_BITS-1:0];
          tdo_pkg::REG_INVERT_MODE: paint_invert = cfg_wdata[0];
          tdo_pkg::REG_MOVE_RADIUS: move_rad = 32'(cfg_wdata);
          tdo_pkg::REG_DOWN_RADIUS: down_rad = 32'(cfg_wdata);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (offer.action == tdo_pkg::ACT_PIXEL) begin
          shade_q.push_back(offer.pin ? offer.pin_exp : shade_pixel(offer));
        end else if (offer.action == tdo_pkg::ACT_UP) begin
          disc_on[offer.slot] = 1'b0;
        end else begin
          disc_on[offer.slot] = 1'b1;
          disc_down[offer.slot] = (offer.action == tdo_pkg::ACT_DOWN);
          disc_x[offer.slot] = offer.pos_x;
          disc_y[offer.slot] = offer.pos_y;
        end
      end
      if (out_valid && out_ready) begin
        if (shade_q.size() == 0) begin
          $error("pixel result transfer with no pixel outstanding");
          fails++;
        end else begin
          want = shade_q.pop_front();
          fails += field_bad("out_red", 32'(want.pix.red), 32'(out_red));
          fails += field_bad("out_green", 32'(want.pix.green), 32'(out_green));
          fails += field_bad("out_blue", 32'(want.pix.blue), 32'(out_blue));
          fails += field_bad("out_alpha", 32'(want.pix.alpha), 32'(out_alpha));
          fails += field_bad("out_covered", 32'(want.covered), 32'(out_covered));
        end
      end
    end
  end

  // receiver
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  task automatic send_item(item_t it);
    if (!steady && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    offer <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // events leave no trace on the output, so give the pipe time to empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shade_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [tdo_pkg::CFG_IDX_BITS-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[tdo_pkg::CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(int unsigned red, int unsigned green, int unsigned blue,
                              int unsigned invert, int unsigned mrad, int unsigned drad);
    write_reg(tdo_pkg::REG_TOUCH_RED, red);
    write_reg(tdo_pkg::REG_TOUCH_GREEN, green);
    write_reg(tdo_pkg::REG_TOUCH_BLUE, blue);
    write_reg(tdo_pkg::REG_INVERT_MODE, invert);
    write_reg(tdo_pkg::REG_MOVE_RADIUS, mrad);
    write_reg(tdo_pkg::REG_DOWN_RADIUS, drad);
  endtask

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // mostly touches and pixels clustered around recent touch points
  function automatic item_t random_item(int unsigned mrad, int unsigned drad);
    item_t it;
    int unsigned pick, s, reach;
    it = '0;
    pick = $urandom_range(99);
    s = $urandom_range(tdo_pkg::SLOTS - 1);
    it.slot = tdo_pkg::SLOT_BITS'(s);
    it.pix = $urandom;
    if (pick < 60) it.action = tdo_pkg::ACT_PIXEL;
    else if (pick < 72) it.action = tdo_pkg::ACT_MOVE;
    else if (pick < 85) it.action = tdo_pkg::ACT_DOWN;
    else it.action = tdo_pkg::ACT_UP;
    if (it.action == tdo_pkg::ACT_PIXEL) begin
      reach = ($urandom_range(1) != 0) ? mrad : drad;
      if (reach > 48) reach = 48;
      reach++;
    end else begin
      reach = 8;
    end
    if ($urandom_range(9) < 3) begin
      it.pos_x = tdo_pkg::COORD_BITS'($urandom_range(COORD_MAX));
      it.pos_y = tdo_pkg::COORD_BITS'($urandom_range(COORD_MAX));
    end else begin
      it.pos_x = tdo_pkg::COORD_BITS'(
        clamp_coord(near_x[s] + int'($urandom_range(2 * reach)) - int'(reach)));
      it.pos_y = tdo_pkg::COORD_BITS'(
        clamp_coord(near_y[s] + int'($urandom_range(2 * reach)) - int'(reach)));
    end
    if (it.action == tdo_pkg::ACT_MOVE || it.action == tdo_pkg::ACT_DOWN) begin
      near_x[$urandom_range(tdo_pkg::SLOTS - 1)] = int'(it.pos_x);
      near_y[s] = int'(it.pos_y);
      near_x[s] = int'(it.pos_x);
    end
    return it;
  endfunction

  initial begin
    int unsigned mrad, drad;
    foreach (near_x[i]) begin
      near_x[i] = 0;
      near_y[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == INVERT_FROM) begin
        drain();
        load_setting(0, 255, 128, 1, 0, 1023);
      end
      send_item(directed_items[i]);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      steady = 1'b0;
      case (ph)
        0: begin mrad = 0; drad = 1023; load_setting(0, 255, 0, 0, mrad, drad); end
        1: begin mrad = 5; drad = 12; load_setting($urandom, $urandom, $urandom, 1, mrad, drad); end
        2: begin
          mrad = $urandom_range(40);
          drad = $urandom_range(40);
          load_setting($urandom, $urandom, $urandom, 0, mrad, drad);
          // stall the output so the pipe fills and in_ready drops
          hold_req = 1'b1;
        end
        3: begin
          mrad = 1023;
          drad = 0;
          load_setting(255, 0, 255, 1, mrad, drad);
          steady = 1'b1;
        end
        4: begin
          mrad = $urandom_range(40);
          drad = $urandom_range(40);
          load_setting($urandom, $urandom, $urandom, 1, mrad, drad);
        end
        default: begin
          mrad = MOVE_RAD_RST;
          drad = DOWN_RAD_RST;
          load_setting($urandom, $urandom, $urandom, 0, mrad, drad);
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(mrad, drad));
    end
    steady = 1'b0;
    drain();

    if (fails == 0 && shade_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
